// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check prop on every clock edge outside reset
`define QBN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qbn assertion failed");
// Check that cons holds in the cycle after ante
`define QBN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qbn assertion failed");
`else
`define QBN_ASSERT(lbl, clk, rstn, prop)
`define QBN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/qbn_pkg.sv -----
`default_nettype none
package qbn_pkg;
    localparam int unsigned DIV_STEPS   = 31;
    localparam int unsigned SQRT_STEPS  = 16;
    localparam int unsigned BLEND_DEPTH = 4;

    localparam logic [16:0] ONE_Q15      = 17'd32768;
    localparam logic [16:0] WEIGHT_RESET = 17'd32113;

    typedef logic [3:0][15:0] quat_t;

    typedef struct packed {
        quat_t b;
        logic  nz;
    } side_t;

    // Clamp a signed value to 16-bit signed range
    function automatic logic [15:0] sat19(input logic signed [18:0] v);
        logic [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'h7fff;
        end else if (v < -19'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/qbn_blend.sv -----
`default_nettype none
module qbn_blend (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [16:0]           alpha,
    input  wire qbn_pkg::quat_t        imu,
    input  wire qbn_pkg::quat_t        odo,
    output logic                       out_valid,
    output qbn_pkg::side_t             side,
    output logic [32:0]                s_sum,
    output logic [3:0][30:0]           msq
);
    logic [qbn_pkg::BLEND_DEPTH-1:0] vld_reg;
    logic [16:0]                     beta;
    logic signed [33:0]              pi_reg [4];
    logic signed [33:0]              po_reg [4];
    logic signed [33:0]              acc [4];
    qbn_pkg::quat_t                  b_next;
    qbn_pkg::quat_t                  b2_reg;
    qbn_pkg::quat_t                  b3_reg;
    qbn_pkg::quat_t                  b4_reg;
    logic signed [31:0]              sq [4];
    logic [3:0][30:0]                sq_reg;
    logic [3:0][30:0]                m4_reg;
    logic [32:0]                     s_reg;

    assign beta = qbn_pkg::ONE_Q15 - alpha;

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[qbn_pkg::BLEND_DEPTH-2:0], in_valid};
        end
    end

    // Stage 1: weight products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                pi_reg[k] <= $signed({1'b0, alpha}) * $signed(imu[k]);
                po_reg[k] <= $signed({1'b0, beta}) * $signed(odo[k]);
            end
        end
    end

    // Stage 2: round half up, floor shift, clamp
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc[k]    = pi_reg[k] + po_reg[k] + 34'sd16384;
            b_next[k] = qbn_pkg::sat19(acc[k][33:15]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b2_reg <= b_next;
        end
    end

    // Stage 3: squares
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sq[k] = $signed(b2_reg[k]) * $signed(b2_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b3_reg <= b2_reg;
            for (int k = 0; k < 4; k++) begin
                sq_reg[k] <= sq[k][30:0];
            end
        end
    end

    // Stage 4: sum of squares
    always_ff @(posedge aclk) begin
        if (en) begin
            b4_reg <= b3_reg;
            m4_reg <= sq_reg;
            s_reg  <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]}
                    + {2'b00, sq_reg[2]} + {2'b00, sq_reg[3]};
        end
    end

    assign out_valid = vld_reg[qbn_pkg::BLEND_DEPTH-1];
    assign side      = {b4_reg, (s_reg != 33'd0)};
    assign s_sum     = s_reg;
    assign msq       = m4_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/qbn_div.sv -----
`default_nettype none
module qbn_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire qbn_pkg::side_t        side_in,
    input  wire logic [32:0]           s_in,
    input  wire logic [3:0][30:0]      m_in,
    output logic                       out_valid,
    output qbn_pkg::side_t             side_out,
    output logic [3:0][30:0]           q_out
);
    logic             vld_reg  [qbn_pkg::DIV_STEPS];
    qbn_pkg::side_t   side_reg [qbn_pkg::DIV_STEPS];
    logic [32:0]      s_reg    [qbn_pkg::DIV_STEPS];
    logic [3:0][32:0] rem_reg  [qbn_pkg::DIV_STEPS];
    logic [3:0][30:0] q_reg    [qbn_pkg::DIV_STEPS];

    // One quotient bit per stage: floor(m * 2^30 / S)
    for (genvar j = 0; j < qbn_pkg::DIV_STEPS; j++) begin : g_step
        logic             v_prev;
        qbn_pkg::side_t   side_prev;
        logic [32:0]      s_prev;
        logic [3:0][32:0] rem_prev;
        logic [3:0][30:0] q_prev;
        logic [33:0]      trial [4];
        logic [3:0][32:0] rem_next;
        logic [3:0][30:0] q_next;

        if (j == 0) begin : g_first
            always_comb begin
                v_prev    = in_valid;
                side_prev = side_in;
                s_prev    = s_in;
                q_prev    = '0;
                for (int k = 0; k < 4; k++) begin
                    rem_prev[k] = {2'b00, m_in[k]};
                end
            end
        end else begin : g_rest
            always_comb begin
                v_prev    = vld_reg[j-1];
                side_prev = side_reg[j-1];
                s_prev    = s_reg[j-1];
                rem_prev  = rem_reg[j-1];
                q_prev    = q_reg[j-1];
            end
        end

        // Compare and subtract
        always_comb begin
            for (int k = 0; k < 4; k++) begin
                trial[k] = (j == 0) ? {1'b0, rem_prev[k]} : {rem_prev[k], 1'b0};
                if (trial[k] >= {1'b0, s_prev}) begin
                    rem_next[k] = 33'(trial[k] - {1'b0, s_prev});
                    q_next[k]   = {q_prev[k][29:0], 1'b1};
                end else begin
                    rem_next[k] = trial[k][32:0];
                    q_next[k]   = {q_prev[k][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= side_prev;
                s_reg[j]    <= s_prev;
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[qbn_pkg::DIV_STEPS-1];
    assign side_out  = side_reg[qbn_pkg::DIV_STEPS-1];
    assign q_out     = q_reg[qbn_pkg::DIV_STEPS-1];
endmodule
`default_nettype wire

// ----- hw/rtl/qbn_sqrt.sv -----
`default_nettype none
module qbn_sqrt (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire qbn_pkg::side_t        side_in,
    input  wire logic [3:0][30:0]      x_in,
    output logic                       out_valid,
    output qbn_pkg::side_t             side_out,
    output logic [3:0][15:0]           root_out
);
    logic             vld_reg  [qbn_pkg::SQRT_STEPS];
    qbn_pkg::side_t   side_reg [qbn_pkg::SQRT_STEPS];
    logic [3:0][30:0] x_reg    [qbn_pkg::SQRT_STEPS];
    logic [3:0][17:0] rem_reg  [qbn_pkg::SQRT_STEPS];
    logic [3:0][15:0] root_reg [qbn_pkg::SQRT_STEPS];

    // One root bit per stage, two radicand bits consumed
    for (genvar j = 0; j < qbn_pkg::SQRT_STEPS; j++) begin : g_step
        logic             v_prev;
        qbn_pkg::side_t   side_prev;
        logic [3:0][30:0] x_prev;
        logic [3:0][17:0] rem_prev;
        logic [3:0][15:0] root_prev;
        logic [31:0]      xx [4];
        logic [19:0]      rem_sh [4];
        logic [19:0]      trial [4];
        logic [3:0][17:0] rem_next;
        logic [3:0][15:0] root_next;

        if (j == 0) begin : g_first
            always_comb begin
                v_prev    = in_valid;
                side_prev = side_in;
                x_prev    = x_in;
                rem_prev  = '0;
                root_prev = '0;
            end
        end else begin : g_rest
            always_comb begin
                v_prev    = vld_reg[j-1];
                side_prev = side_reg[j-1];
                x_prev    = x_reg[j-1];
                rem_prev  = rem_reg[j-1];
                root_prev = root_reg[j-1];
            end
        end

        always_comb begin
            for (int k = 0; k < 4; k++) begin
                xx[k]     = {1'b0, x_prev[k]};
                rem_sh[k] = {rem_prev[k], xx[k][31-2*j -: 2]};
                trial[k]  = {2'b00, root_prev[k], 2'b01};
                if (rem_sh[k] >= trial[k]) begin
                    rem_next[k]  = 18'(rem_sh[k] - trial[k]);
                    root_next[k] = {root_prev[k][14:0], 1'b1};
                end else begin
                    rem_next[k]  = rem_sh[k][17:0];
                    root_next[k] = {root_prev[k][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= side_prev;
                x_reg[j]    <= x_prev;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[qbn_pkg::SQRT_STEPS-1];
    assign side_out  = side_reg[qbn_pkg::SQRT_STEPS-1];
    assign root_out  = root_reg[qbn_pkg::SQRT_STEPS-1];
endmodule
`default_nettype wire

// ----- hw/rtl/quaternion_blend_normalize.sv -----
`default_nettype none
`include "assert_macros.svh"
// Quaternion nlerp: blends an IMU and an odometry quaternion (Q2.14) with the
// IMU weight alpha (Q1.15, values above 1.0 act as 1.0) and scales the blend to
// unit length with exact round-to-nearest. One transaction enters per cycle
// while the output is not stalled. Each passes through 4 blend/norm stages,
// a 31-stage bit-per-stage divider, a 16-stage bit-per-stage square root
// and the output register. Any stall on m_ready freezes the whole pipeline.
// A blend of zero length is passed through with m_was_normalized low.
module quaternion_blend_normalize (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_imu_qx,
    input  wire logic [15:0] s_imu_qy,
    input  wire logic [15:0] s_imu_qz,
    input  wire logic [15:0] s_imu_qw,
    input  wire logic [15:0] s_odo_qx,
    input  wire logic [15:0] s_odo_qy,
    input  wire logic [15:0] s_odo_qz,
    input  wire logic [15:0] s_odo_qw,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_fused_qx,
    output logic [15:0]      m_fused_qy,
    output logic [15:0]      m_fused_qz,
    output logic [15:0]      m_fused_qw,
    output logic             m_was_normalized
);
    logic [16:0]          weight_reg;
    logic                 en;
    qbn_pkg::quat_t       imu;
    qbn_pkg::quat_t       odo;
    logic                 bl_valid;
    qbn_pkg::side_t       bl_side;
    logic [32:0]          bl_s;
    logic [3:0][30:0]     bl_m;
    logic                 dv_valid;
    qbn_pkg::side_t       dv_side;
    logic [3:0][30:0]     dv_q;
    logic                 sq_valid;
    qbn_pkg::side_t       sq_side;
    logic [3:0][15:0]     sq_root;
    logic [15:0]          mid [4];
    logic signed [18:0]   mag [4];
    qbn_pkg::quat_t       res_next;
    logic                 m_valid_reg;
    qbn_pkg::quat_t       res_reg;
    logic                 norm_reg;

    // Hold the clamped weight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= qbn_pkg::WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            weight_reg <= ({1'b0, cfg_wr_data} > qbn_pkg::ONE_Q15) ?
                          qbn_pkg::ONE_Q15 : {1'b0, cfg_wr_data};
        end
    end

    // Advance the pipeline unless the output transaction is stalled
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign imu = {s_imu_qw, s_imu_qz, s_imu_qy, s_imu_qx};
    assign odo = {s_odo_qw, s_odo_qz, s_odo_qy, s_odo_qx};

    qbn_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .alpha     (weight_reg),
        .imu       (imu),
        .odo       (odo),
        .out_valid (bl_valid),
        .side      (bl_side),
        .s_sum     (bl_s),
        .msq       (bl_m)
    );

    qbn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (bl_valid),
        .side_in   (bl_side),
        .s_in      (bl_s),
        .m_in      (bl_m),
        .out_valid (dv_valid),
        .side_out  (dv_side),
        .q_out     (dv_q)
    );

    qbn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .side_in   (dv_side),
        .x_in      (dv_q),
        .out_valid (sq_valid),
        .side_out  (sq_side),
        .root_out  (sq_root)
    );

    // Pick the largest odd bound, restore sign, or pass a zero blend through
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mid[k] = 16'((17'(sq_root[k]) + 17'd1) >> 1);
            mag[k] = $signed({3'b000, mid[k]});
            if (!sq_side.nz) begin
                res_next[k] = sq_side.b[k];
            end else if (sq_side.b[k][15]) begin
                res_next[k] = qbn_pkg::sat19(-mag[k]);
            end else begin
                res_next[k] = qbn_pkg::sat19(mag[k]);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && sq_valid) begin
            res_reg  <= res_next;
            norm_reg <= sq_side.nz;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_fused_qx       = res_reg[0];
    assign m_fused_qy       = res_reg[1];
    assign m_fused_qz       = res_reg[2];
    assign m_fused_qw       = res_reg[3];
    assign m_was_normalized = norm_reg;

    `QBN_ASSERT(a_zero_pass, aclk, aresetn,
        (m_valid && !m_was_normalized) |->
        (m_fused_qx == 16'd0 && m_fused_qy == 16'd0 &&
         m_fused_qz == 16'd0 && m_fused_qw == 16'd0))
    `QBN_ASSERT(a_unit_bound, aclk, aresetn,
        (m_valid && m_was_normalized) |->
        ($signed(m_fused_qx) <= 16'sd16384 && $signed(m_fused_qx) >= -16'sd16384 &&
         $signed(m_fused_qw) <= 16'sd16384 && $signed(m_fused_qw) >= -16'sd16384))
    `QBN_ASSERT_NEXT(a_weight_clamp, aclk, aresetn, cfg_wr_en, weight_reg <= qbn_pkg::ONE_Q15)
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PIPE_DEPTH  = 60;
    localparam logic [16:0] Q15_ONE     = 17'd32768;
    localparam int unsigned Q14_ONE     = 16384;

    typedef struct {
        logic [15:0] q [4];
        logic        norm;
    } fused_t;

    typedef struct {
        logic [15:0] imu [4];
        logic [15:0] odo [4];
    } pair_t;

    // Directed rows: weight to load first (cfg_set), inputs, and optional typed result
    typedef struct {
        bit          cfg_set;
        logic [15:0] weight;
        pair_t       pair;
        bit          has_exp;
        fused_t      exp_res;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_imu_qx, s_imu_qy, s_imu_qz, s_imu_qw;
    logic [15:0] s_odo_qx, s_odo_qy, s_odo_qz, s_odo_qw;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_fused_qx, m_fused_qy, m_fused_qz, m_fused_qw;
    logic        m_was_normalized;

    quaternion_blend_normalize dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_imu_qx         (s_imu_qx),
        .s_imu_qy         (s_imu_qy),
        .s_imu_qz         (s_imu_qz),
        .s_imu_qw         (s_imu_qw),
        .s_odo_qx         (s_odo_qx),
        .s_odo_qy         (s_odo_qy),
        .s_odo_qz         (s_odo_qz),
        .s_odo_qw         (s_odo_qw),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fused_qx       (m_fused_qx),
        .m_fused_qy       (m_fused_qy),
        .m_fused_qz       (m_fused_qz),
        .m_fused_qw       (m_fused_qw),
        .m_was_normalized (m_was_normalized)
    );

    fused_t      fused_queue [$];
    logic [15:0] alpha_reg;
    int unsigned cycle_cnt;
    int unsigned mismatch_cnt;
    int unsigned sent_cnt;
    int unsigned recv_cnt;
    int unsigned zero_norm_cnt;
    int unsigned unit_weight_cnt;
    bit          calm_mode;
    bit          hold_off_req;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Exact rounded magnitude of |b|*2^14/sqrt(s), ties away from zero
    function automatic int unsigned unit_mag(input int unsigned mag, input longint unsigned s);
        longint unsigned rhs;
        longint unsigned t;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        rhs = (longint'(mag) * mag) << 30;
        lo = 0;
        hi = Q14_ONE;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * longint'(mid) - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Blend two quaternions with the current weight and scale to unit length
    function automatic fused_t nlerp_fuse(input pair_t p, input logic [15:0] w);
        fused_t          r;
        longint          a;
        longint          acc;
        longint          bl [4];
        longint unsigned s;
        longint          q;
        a = (w > Q15_ONE) ? 32768 : longint'(w);
        s = 0;
        for (int k = 0; k < 4; k++) begin
            acc = a * longint'($signed(p.imu[k])) + (32768 - a) * longint'($signed(p.odo[k]))
                + 16384;
            acc = acc >>> 15;
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            bl[k] = acc;
            s += longint'(acc * acc);
        end
        r.norm = (s != 0);
        for (int k = 0; k < 4; k++) begin
            if (s == 0) begin
                q = bl[k];
            end else begin
                q = unit_mag(32'((bl[k] < 0) ? -bl[k] : bl[k]), s);
                if (bl[k] < 0) q = -q;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
            end
            r.q[k] = q[15:0];
        end
        return r;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        logic [15:0] base [4];
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++) begin
            base[k] = 16'($urandom);
            case (mode)
                0, 1, 2: begin
                    // unit-scale components, each between -1.0 and 1.0
                    p.imu[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
                    p.odo[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
                end
                3: begin
                    // opposite quaternions, blend can cancel to zero
                    p.imu[k] = base[k];
                    p.odo[k] = -base[k];
                end
                4: begin
                    p.imu[k] = 16'($signed($urandom_range(0, 6)) - 3);
                    p.odo[k] = 16'($signed($urandom_range(0, 6)) - 3);
                end
                5: begin
                    p.imu[k] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    p.odo[k] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                end
                6: begin
                    p.imu[k] = base[k];
                    p.odo[k] = base[k];
                end
                default: begin
                    p.imu[k] = 16'($urandom);
                    p.odo[k] = 16'($urandom);
                end
            endcase
        end
        return p;
    endfunction

    task automatic load_weight(input logic [15:0] w);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        alpha_reg = w;
    endtask

    // Stop offering, wait until every expected result has come, then let the pipeline drain
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (fused_queue.size() != 0) @(negedge aclk);
        repeat (PIPE_DEPTH) @(negedge aclk);
    endtask

    // Offer one transaction and hold it until accepted; valid stays high
    // afterwards until the next idle cycle or the caller drops it
    task automatic send_pair(input pair_t p);
        fused_t e;
        while (!calm_mode && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_imu_qx <= p.imu[0];
        s_imu_qy <= p.imu[1];
        s_imu_qz <= p.imu[2];
        s_imu_qw <= p.imu[3];
        s_odo_qx <= p.odo[0];
        s_odo_qy <= p.odo[1];
        s_odo_qz <= p.odo[2];
        s_odo_qw <= p.odo[3];
        e = nlerp_fuse(p, alpha_reg);
        do @(posedge aclk); while (!s_ready);
        fused_queue.push_back(e);
        sent_cnt++;
        if (!e.norm) zero_norm_cnt++;
        if (alpha_reg >= Q15_ONE) unit_weight_cnt++;
        @(negedge aclk);
    endtask

    function automatic fused_t mk_res(input logic [15:0] x, input logic [15:0] y,
                                      input logic [15:0] z, input logic [15:0] w,
                                      input logic n);
        fused_t r;
        r.q[0] = x; r.q[1] = y; r.q[2] = z; r.q[3] = w; r.norm = n;
        return r;
    endfunction

    function automatic pair_t mk_pair(input logic [15:0] ix, input logic [15:0] iy,
                                      input logic [15:0] iz, input logic [15:0] iw,
                                      input logic [15:0] ox, input logic [15:0] oy,
                                      input logic [15:0] oz, input logic [15:0] ow);
        pair_t p;
        p.imu[0] = ix; p.imu[1] = iy; p.imu[2] = iz; p.imu[3] = iw;
        p.odo[0] = ox; p.odo[1] = oy; p.odo[2] = oz; p.odo[3] = ow;
        return p;
    endfunction

    // Receiver: random stalls outside calm mode, plus a long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_req) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm_mode ? 1'b1 : ($urandom_range(0, 99) >= 35);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        fused_t got;
        fused_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = mk_res(m_fused_qx, m_fused_qy, m_fused_qz, m_fused_qw, m_was_normalized);
            recv_cnt++;
            if (fused_queue.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result transaction %h %h %h %h %b",
                    got.q[0], got.q[1], got.q[2], got.q[3], got.norm);
            end else begin
                exp_r = fused_queue.pop_front();
                if (got.q != exp_r.q || got.norm !== exp_r.norm) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch #%0d: exp %h %h %h %h n=%b got %h %h %h %h n=%b",
                            recv_cnt, exp_r.q[0], exp_r.q[1], exp_r.q[2], exp_r.q[3],
                            exp_r.norm, got.q[0], got.q[1], got.q[2], got.q[3], got.norm);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Verification failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted here, while the sender keeps going
    initial begin
        hold_off_req = 1'b0;
        wait (sent_cnt >= 150);
        @(negedge aclk);
        hold_off_req = 1'b1;
        repeat (300) @(negedge aclk);
        hold_off_req = 1'b0;
    end

    initial begin
        row_t        rows [$];
        row_t        r;
        logic [15:0] weights [6];
        cycle_cnt = 0; mismatch_cnt = 0; sent_cnt = 0; recv_cnt = 0;
        zero_norm_cnt = 0; unit_weight_cnt = 0; calm_mode = 0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; s_valid = 1'b0;
        {s_imu_qx, s_imu_qy, s_imu_qz, s_imu_qw} = '0;
        {s_odo_qx, s_odo_qy, s_odo_qz, s_odo_qw} = '0;
        alpha_reg = 16'(32113);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows; expectations typed where obvious
        r = '{default: '0};
        r.pair = mk_pair(0, 0, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1; r.exp_res = mk_res(0, 0, 0, 0, 0);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(0, 0, 0, 16384, 0, 0, 0, 16384);
        r.has_exp = 1; r.exp_res = mk_res(0, 0, 0, 16384, 1);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                         16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(1, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        // Weight one: IMU passes alone
        r = '{default: '0};
        r.cfg_set = 1; r.weight = 16'(32768);
        r.pair = mk_pair(0, 16384, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        r.has_exp = 1; r.exp_res = mk_res(0, 16384, 0, 0, 1);
        rows.push_back(r);
        // Weight above one acts as one
        r = '{default: '0};
        r.cfg_set = 1; r.weight = 16'hffff;
        r.pair = mk_pair(0, 0, 16'hc000, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        r.has_exp = 1; r.exp_res = mk_res(0, 0, 16'hc000, 0, 1);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(0, 0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        r.has_exp = 1; r.exp_res = mk_res(0, 0, 0, 0, 0);
        rows.push_back(r);
        // Weight zero: odometry passes alone
        r = '{default: '0};
        r.cfg_set = 1; r.weight = 16'd0;
        r.pair = mk_pair(16'h7fff, 0, 0, 0, 16384, 0, 0, 0);
        r.has_exp = 1; r.exp_res = mk_res(16384, 0, 0, 0, 1);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000);
        rows.push_back(r);
        // Half weight: opposite inputs cancel to zero norm
        r = '{default: '0};
        r.cfg_set = 1; r.weight = 16'd16384;
        r.pair = mk_pair(100, 16'hff9c, 7, 16'hfff9, 16'hff9c, 100, 16'hfff9, 7);
        r.has_exp = 1; r.exp_res = mk_res(0, 0, 0, 0, 0);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                         16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        rows.push_back(r);
        r = '{default: '0};
        r.pair = mk_pair(1, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r = '{default: '0};
        r.cfg_set = 1; r.weight = 16'd1;
        r.pair = mk_pair(16'h5555, 16'haaaa, 16'h1234, 16'hedcb,
                         16'haaaa, 16'h5555, 16'hfedc, 16'h0123);
        rows.push_back(r);
        r = '{default: '0};
        r.cfg_set = 1; r.weight = 16'd32767;
        r.pair = mk_pair(16'h5555, 16'haaaa, 16'h1234, 16'hedcb,
                         16'haaaa, 16'h5555, 16'hfedc, 16'h0123);
        rows.push_back(r);

        // Walk the table; typed expectations must agree with the predictor
        foreach (rows[i]) begin
            if (rows[i].cfg_set) begin
                drain_pipe();
                load_weight(rows[i].weight);
            end
            if (rows[i].has_exp && nlerp_fuse(rows[i].pair, alpha_reg) != rows[i].exp_res) begin
                mismatch_cnt++;
                $display("directed row %0d: predictor disagrees with typed result", i);
            end
            send_pair(rows[i].pair);
        end

        // Random phases across several weights
        weights = '{16'(32113), 16'd0, 16'(32768), 16'hffff, 16'd1, 16'd16384};
        for (int ph = 0; ph < 6; ph++) begin
            drain_pipe();
            load_weight(ph == 0 ? weights[0] : (ph % 2 ? weights[ph] : 16'($urandom)));
            if (ph == 5) load_weight(weights[5]);
            calm_mode = (ph == 2);
            for (int n = 0; n < 155; n++) begin
                send_pair(rand_pair());
                // Sender pause until every result is back
                if (ph == 3 && n == 80) begin
                    s_valid <= 1'b0;
                    while (fused_queue.size() != 0) @(negedge aclk);
                end
            end
        end
        calm_mode = 0;
        drain_pipe();

        $display("sent %0d transactions, received %0d, %0d with zero norm, %0d at full weight",
                 sent_cnt, recv_cnt, zero_norm_cnt, unit_weight_cnt);
        $display("covered weights 0, 1, half, reset, one and above one, with stalls and hold-off");
        if (mismatch_cnt == 0 && fused_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d left over", mismatch_cnt, fused_queue.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/qbn_pkg.sv
hw/rtl/qbn_blend.sv
hw/rtl/qbn_div.sv
hw/rtl/qbn_sqrt.sv
hw/rtl/quaternion_blend_normalize.sv
dv/tb.sv
